### design/cet_pkg.sv
// ----------------------------------------------------------------------------
// cet_pkg
// Shared types, token and mode codes, character constants and class tests
// for the condition expression tokenizer.
// ----------------------------------------------------------------------------
package cet_pkg;

   localparam int MAX_EXPR_LEN_DEFAULT = 1024;
   localparam int TOK_POS_W            = 10;
   localparam int TOK_KIND_W           = 5;
   localparam int BUNDLE_DEPTH         = 3;

   typedef enum logic [TOK_KIND_W-1:0] {
      KIND_AND     = 5'd0,
      KIND_OR      = 5'd1,
      KIND_NOT     = 5'd2,
      KIND_NEQ     = 5'd3,
      KIND_EQ      = 5'd4,
      KIND_LPAREN  = 5'd5,
      KIND_RPAREN  = 5'd6,
      KIND_ARGSEP  = 5'd7,
      KIND_NODE    = 5'd8,
      KIND_BOOL    = 5'd9,
      KIND_LAMBDA  = 5'd10,
      KIND_KEY     = 5'd11,
      KIND_INTEGER = 5'd12,
      KIND_FLOAT   = 5'd13,
      KIND_STRING  = 5'd14,
      KIND_STOP    = 5'd15,
      KIND_ERROR   = 5'd16
   } kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'd0,
      MODE_BANG   = 4'd1,
      MODE_AMP    = 4'd2,
      MODE_PIPE   = 4'd3,
      MODE_EQ1    = 4'd4,
      MODE_IDENT  = 4'd5,
      MODE_INT    = 4'd6,
      MODE_FLOAT  = 4'd7,
      MODE_STRING = 4'd8,
      MODE_DEAD   = 4'd9
   } mode_type;

   // Bool word tracker states
   localparam logic [3:0] BW_NONE  = 4'd0;
   localparam logic [3:0] BW_T     = 4'd1;
   localparam logic [3:0] BW_TR    = 4'd2;
   localparam logic [3:0] BW_TRU   = 4'd3;
   localparam logic [3:0] BW_TRUE  = 4'd4;
   localparam logic [3:0] BW_F     = 4'd5;
   localparam logic [3:0] BW_FA    = 4'd6;
   localparam logic [3:0] BW_FAL   = 4'd7;
   localparam logic [3:0] BW_FALS  = 4'd8;
   localparam logic [3:0] BW_FALSE = 4'd9;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_UPPER_T = 8'h54;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_T = 8'h74;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_LOWER_U = 8'h75;
   localparam logic [7:0] CH_LOWER_E = 8'h65;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_L = 8'h6C;
   localparam logic [7:0] CH_LOWER_S = 8'h73;

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_expression;
   } req_item_type;

   typedef struct packed {
      logic [TOK_KIND_W-1:0] token_kind;
      logic [TOK_POS_W-1:0]  token_start;
      logic [TOK_POS_W-1:0]  token_length;
      logic                  last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]                         count;
      rsp_item_type [BUNDLE_DEPTH-1:0]    tok;
   } bundle_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || (c == 8'h5F);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_str_char(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
   endfunction

   function automatic logic [3:0] bool_next(input logic [3:0] tr, input logic [7:0] c);
      logic [3:0] r;
      r = BW_NONE;
      case (tr)
         BW_T:    r = (c == CH_LOWER_R) ? BW_TR    : BW_NONE;
         BW_TR:   r = (c == CH_LOWER_U) ? BW_TRU   : BW_NONE;
         BW_TRU:  r = (c == CH_LOWER_E) ? BW_TRUE  : BW_NONE;
         BW_F:    r = (c == CH_LOWER_A) ? BW_FA    : BW_NONE;
         BW_FA:   r = (c == CH_LOWER_L) ? BW_FAL   : BW_NONE;
         BW_FAL:  r = (c == CH_LOWER_S) ? BW_FALS  : BW_NONE;
         BW_FALS: r = (c == CH_LOWER_E) ? BW_FALSE : BW_NONE;
         default: r = BW_NONE;
      endcase
      return r;
   endfunction

endpackage

### design/cet_lexer.sv
// ----------------------------------------------------------------------------
// cet_lexer
// Lexer state and the single-pass step: one character in, a bundle of up to
// three tokens out.
// ----------------------------------------------------------------------------
module cet_lexer #(
   parameter int MAX_EXPR_LEN = cet_pkg::MAX_EXPR_LEN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  cet_pkg::req_item_type item,
   output cet_pkg::bundle_type   bundle
);

   localparam int IW = $clog2(MAX_EXPR_LEN);
   localparam logic [IW:0]   MOD      = (IW+1)'(MAX_EXPR_LEN);
   localparam logic [IW-1:0] LAST_POS = IW'(MAX_EXPR_LEN - 1);

   typedef struct packed {
      cet_pkg::mode_type mode;
      logic              emit;
      cet_pkg::kind_type kind;
      logic              set_trk;
      logic [3:0]        trk;
      logic              quote;
   } start_type;

   cet_pkg::mode_type mode_ff, mode_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [IW-1:0]     start_ff, start_in;
   logic [3:0]        trk_ff, trk_in;

   cet_pkg::rsp_item_type toks [4];
   logic [2:0]            n;
   logic [IW-1:0]         p, endpos;
   logic [7:0]            c;
   start_type             st;

   function automatic logic [IW-1:0] inc_pos(input logic [IW-1:0] x);
      return (x == LAST_POS) ? '0 : x + IW'(1);
   endfunction

   function automatic logic [IW-1:0] span(input logic [IW-1:0] from, input logic [IW-1:0] to);
      logic [IW:0] d;
      d = {1'b0, to} - {1'b0, from};
      if (d[IW]) d = d + MOD;
      return d[IW-1:0];
   endfunction

   function automatic cet_pkg::rsp_item_type mk(input cet_pkg::kind_type k,
                                                input logic [IW-1:0] s,
                                                input logic [IW-1:0] l);
      cet_pkg::rsp_item_type r;
      r.token_kind   = k;
      r.token_start  = cet_pkg::TOK_POS_W'(s);
      r.token_length = cet_pkg::TOK_POS_W'(l);
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   function automatic cet_pkg::kind_type word_kind(input logic [3:0] tr);
      return (tr == cet_pkg::BW_TRUE || tr == cet_pkg::BW_FALSE) ?
             cet_pkg::KIND_BOOL : cet_pkg::KIND_KEY;
   endfunction

   function automatic start_type start_token(input logic [7:0] ch);
      start_type s;
      s.mode    = cet_pkg::MODE_IDLE;
      s.emit    = 1'b0;
      s.kind    = cet_pkg::KIND_LPAREN;
      s.set_trk = 1'b0;
      s.trk     = cet_pkg::BW_NONE;
      s.quote   = 1'b0;
      case (ch)
         cet_pkg::CH_SPACE:  s.mode = cet_pkg::MODE_IDLE;
         cet_pkg::CH_BANG:   s.mode = cet_pkg::MODE_BANG;
         cet_pkg::CH_AMP:    s.mode = cet_pkg::MODE_AMP;
         cet_pkg::CH_PIPE:   s.mode = cet_pkg::MODE_PIPE;
         cet_pkg::CH_EQUALS: s.mode = cet_pkg::MODE_EQ1;
         cet_pkg::CH_LPAREN: begin s.emit = 1'b1; s.kind = cet_pkg::KIND_LPAREN; end
         cet_pkg::CH_RPAREN: begin s.emit = 1'b1; s.kind = cet_pkg::KIND_RPAREN; end
         cet_pkg::CH_COMMA:  begin s.emit = 1'b1; s.kind = cet_pkg::KIND_ARGSEP; end
         cet_pkg::CH_DOLLAR: begin s.emit = 1'b1; s.kind = cet_pkg::KIND_NODE; end
         cet_pkg::CH_QUOTE:  begin s.mode = cet_pkg::MODE_STRING; s.quote = 1'b1; end
         default: begin
            if (cet_pkg::is_alpha(ch)) begin
               s.mode    = cet_pkg::MODE_IDENT;
               s.set_trk = 1'b1;
               if (ch == cet_pkg::CH_LOWER_T || ch == cet_pkg::CH_UPPER_T) begin
                  s.trk = cet_pkg::BW_T;
               end else if (ch == cet_pkg::CH_LOWER_F || ch == cet_pkg::CH_UPPER_F) begin
                  s.trk = cet_pkg::BW_F;
               end
            end else if (cet_pkg::is_digit(ch)) begin
               s.mode = cet_pkg::MODE_INT;
            end else begin
               s.mode = cet_pkg::MODE_DEAD;
            end
         end
      endcase
      return s;
   endfunction

   assign c      = item.character;
   assign p      = idx_ff;
   assign endpos = inc_pos(idx_ff);
   assign st     = start_token(c);

   always_comb begin
      logic do_start;
      logic pair;
      logic [7:0] want;
      cet_pkg::kind_type pkind;
      mode_in  = mode_ff;
      start_in = start_ff;
      trk_in   = trk_ff;
      idx_in   = endpos;
      n        = '0;
      do_start = 1'b0;
      pair     = 1'b0;
      want     = cet_pkg::CH_AMP;
      pkind    = cet_pkg::KIND_AND;
      for (int i = 0; i < 4; i++) toks[i] = '0;

      case (mode_ff)
         cet_pkg::MODE_IDLE: do_start = 1'b1;
         cet_pkg::MODE_BANG: begin
            if (c == cet_pkg::CH_EQUALS) begin
               toks[n[1:0]] = mk(cet_pkg::KIND_NEQ, start_ff, IW'(2));
               n = n + 3'd1;
               mode_in = cet_pkg::MODE_IDLE;
            end else begin
               toks[n[1:0]] = mk(cet_pkg::KIND_NOT, start_ff, IW'(1));
               n = n + 3'd1;
               do_start = 1'b1;
            end
         end
         cet_pkg::MODE_AMP: begin
            pair = 1'b1; want = cet_pkg::CH_AMP; pkind = cet_pkg::KIND_AND;
         end
         cet_pkg::MODE_PIPE: begin
            pair = 1'b1; want = cet_pkg::CH_PIPE; pkind = cet_pkg::KIND_OR;
         end
         cet_pkg::MODE_EQ1: begin
            pair = 1'b1; want = cet_pkg::CH_EQUALS; pkind = cet_pkg::KIND_EQ;
         end
         cet_pkg::MODE_IDENT: begin
            if (cet_pkg::is_alpha(c) || cet_pkg::is_digit(c)) begin
               trk_in = cet_pkg::bool_next(trk_ff, c);
            end else if (c == cet_pkg::CH_LPAREN) begin
               toks[n[1:0]] = mk(cet_pkg::KIND_LAMBDA, start_ff, span(start_ff, p));
               n = n + 3'd1;
               mode_in = cet_pkg::MODE_IDLE;
            end else begin
               toks[n[1:0]] = mk(word_kind(trk_ff), start_ff, span(start_ff, p));
               n = n + 3'd1;
               do_start = 1'b1;
            end
         end
         cet_pkg::MODE_INT: begin
            if (c == cet_pkg::CH_DOT) begin
               mode_in = cet_pkg::MODE_FLOAT;
            end else if (!cet_pkg::is_digit(c)) begin
               toks[n[1:0]] = mk(cet_pkg::KIND_INTEGER, start_ff, span(start_ff, p));
               n = n + 3'd1;
               do_start = 1'b1;
            end
         end
         cet_pkg::MODE_FLOAT: begin
            if (!cet_pkg::is_digit(c)) begin
               toks[n[1:0]] = mk(cet_pkg::KIND_FLOAT, start_ff, span(start_ff, p));
               n = n + 3'd1;
               do_start = 1'b1;
            end
         end
         cet_pkg::MODE_STRING: begin
            if (c == cet_pkg::CH_QUOTE) begin
               toks[n[1:0]] = mk(cet_pkg::KIND_STRING, start_ff, span(start_ff, p));
               n = n + 3'd1;
               mode_in = cet_pkg::MODE_IDLE;
            end else if (!cet_pkg::is_str_char(c)) begin
               mode_in = cet_pkg::MODE_DEAD;
            end
         end
         default: mode_in = cet_pkg::MODE_DEAD;
      endcase

      if (pair && c != cet_pkg::CH_SPACE) begin
         if (c == want) begin
            toks[n[1:0]] = mk(pkind, start_ff, IW'(2));
            n = n + 3'd1;
            mode_in = cet_pkg::MODE_IDLE;
         end else begin
            mode_in = cet_pkg::MODE_DEAD;
         end
      end

      if (do_start) begin
         mode_in  = st.mode;
         start_in = st.quote ? inc_pos(p) : p;
         if (st.set_trk) trk_in = st.trk;
         if (st.emit) begin
            toks[n[1:0]] = mk(st.kind, p, IW'(1));
            n = n + 3'd1;
         end
      end

      if (item.end_of_expression) begin
         case (mode_in)
            cet_pkg::MODE_IDLE: begin
               toks[n[1:0]] = mk(cet_pkg::KIND_STOP, endpos, '0);
               n = n + 3'd1;
            end
            cet_pkg::MODE_BANG: begin
               toks[n[1:0]] = mk(cet_pkg::KIND_NOT, start_in, IW'(1));
               n = n + 3'd1;
               toks[n[1:0]] = mk(cet_pkg::KIND_STOP, endpos, '0);
               n = n + 3'd1;
            end
            cet_pkg::MODE_IDENT: begin
               toks[n[1:0]] = mk(word_kind(trk_in), start_in, span(start_in, endpos));
               n = n + 3'd1;
               toks[n[1:0]] = mk(cet_pkg::KIND_STOP, endpos, '0);
               n = n + 3'd1;
            end
            cet_pkg::MODE_INT: begin
               toks[n[1:0]] = mk(cet_pkg::KIND_INTEGER, start_in, span(start_in, endpos));
               n = n + 3'd1;
               toks[n[1:0]] = mk(cet_pkg::KIND_STOP, endpos, '0);
               n = n + 3'd1;
            end
            cet_pkg::MODE_FLOAT: begin
               toks[n[1:0]] = mk(cet_pkg::KIND_FLOAT, start_in, span(start_in, endpos));
               n = n + 3'd1;
               toks[n[1:0]] = mk(cet_pkg::KIND_STOP, endpos, '0);
               n = n + 3'd1;
            end
            default: begin
               toks[n[1:0]] = mk(cet_pkg::KIND_ERROR, endpos, '0);
               n = n + 3'd1;
            end
         endcase
         mode_in  = cet_pkg::MODE_IDLE;
         idx_in   = '0;
         start_in = '0;
         trk_in   = cet_pkg::BW_NONE;
      end

      if (n != 3'd0) toks[n[1:0] - 2'd1].last_of_run = 1'b1;
   end

   always_comb begin
      bundle.count = n[1:0];
      for (int i = 0; i < cet_pkg::BUNDLE_DEPTH; i++) bundle.tok[i] = toks[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= cet_pkg::MODE_IDLE;
         idx_ff   <= '0;
         start_ff <= '0;
         trk_ff   <= cet_pkg::BW_NONE;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         idx_ff   <= idx_in;
         start_ff <= start_in;
         trk_ff   <= trk_in;
      end
   end

   a_end_rearms: assert property (@(posedge clock) disable iff (reset)
      step_en && item.end_of_expression |=> mode_ff == cet_pkg::MODE_IDLE && idx_ff == '0)
      else $error("lexer did not rearm after end of expression");

   a_end_reports: assert property (@(posedge clock) disable iff (reset)
      step_en && item.end_of_expression |-> bundle.count != 2'd0)
      else $error("end of expression produced no token");

   a_dead_silent: assert property (@(posedge clock) disable iff (reset)
      step_en && mode_ff == cet_pkg::MODE_DEAD && !item.end_of_expression
      |-> bundle.count == 2'd0)
      else $error("dead lexer produced a token");

endmodule

### design/cet_tokbuf.sv
// ----------------------------------------------------------------------------
// cet_tokbuf
// Result register: holds one bundle of tokens and hands them out one item
// per cycle while the consumer holds rsp_ready high.
// ----------------------------------------------------------------------------
module cet_tokbuf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  cet_pkg::bundle_type   bundle,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cet_pkg::rsp_item_type rsp_data
);

   logic [1:0]            count_ff;
   cet_pkg::rsp_item_type tok_ff [cet_pkg::BUNDLE_DEPTH];
   logic                  pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = tok_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   assign free      = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= bundle.count;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < cet_pkg::BUNDLE_DEPTH; i++) tok_ff[i] <= bundle.tok[i];
      end else if (pop) begin
         for (int i = 0; i < cet_pkg::BUNDLE_DEPTH - 1; i++) tok_ff[i] <= tok_ff[i+1];
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("bundle loaded over pending tokens");

   a_final_marked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && count_ff == 2'd1 |-> rsp_data.last_of_run)
      else $error("final token of a run not marked");

   a_inner_unmarked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && count_ff != 2'd1 |-> !rsp_data.last_of_run)
      else $error("inner token of a run marked as final");

endmodule

### design/condition_expression_tokenizer.sv
// ----------------------------------------------------------------------------
// condition_expression_tokenizer
// Streaming lexer: one character item in, zero to three token items out.
// A character is accepted into the input register, stepped by the lexer into
// the token bundle register, and its first token is offered from there.
// Throughput: one character per cycle while each gives at most one token and
// rsp_ready stays high; a character that gives several tokens holds the input
// until the single-entry token bundle register hands out its last token.
// Reset: synchronous; clears lexer mode, positions and all valid flags.
// ----------------------------------------------------------------------------
module condition_expression_tokenizer #(
   parameter int MAX_EXPR_LEN = cet_pkg::MAX_EXPR_LEN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cet_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cet_pkg::rsp_item_type rsp_data
);

   logic                  in_valid_ff;
   cet_pkg::req_item_type in_item_ff;
   logic                  advance;
   logic                  buf_free;
   cet_pkg::bundle_type   bundle;

   assign advance   = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   cet_lexer #(
      .MAX_EXPR_LEN (MAX_EXPR_LEN)
   ) u_lexer (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .bundle  (bundle)
   );

   cet_tokbuf u_tokbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .bundle    (bundle),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
